FILE: rtl/crwt_pkg.sv
package crwt_pkg;

  // Ring geometry
  localparam int DEPTH  = 8;
  localparam int SLOT_W = $clog2(DEPTH);

  // Field widths
  localparam int H_W    = 16;
  localparam int T_W    = 32;
  localparam int RATE_W = 16;

  // Rate scaling and the divisor used for a zero time difference
  localparam int RATE_SCALE = 1000;
  localparam int ZERO_DT    = 1000;

  // Shared divider: dividend holds dh * 1000, divisor holds a 16-bit dt
  localparam int DVD_W     = 26;
  localparam int DIV_W     = 16;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT_LOW  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT_HIGH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_LOW    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE_HIGH   = 2'd3;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_LD0,
    ST_PAIR,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic rd_first;
    logic prev_load;
    logic pair_load;
    logic div_step;
    logic acc;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;
    logic pair_last;
  } sts_t;

endpackage

FILE: rtl/crwt_ctrl.sv
module crwt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  crwt_pkg::sts_t  sts,
  output crwt_pkg::cmd_t  cmd
);
  import crwt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_acc) state_nxt = ST_RD0;
      ST_RD0:     state_nxt = ST_LD0;
      ST_LD0:     state_nxt = ST_PAIR;
      ST_PAIR:    state_nxt = ST_DIV;
      ST_DIV:     if (sts.div_last) state_nxt = ST_ACC;
      ST_ACC:     state_nxt = sts.pair_last ? ST_FIN : ST_PAIR;
      ST_FIN:     if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:    cmd.capture = in_acc;
      ST_RD0: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = 1'b1;
      end
      ST_LD0: begin
        cmd.prev_load = 1'b1;
        cmd.rd_en     = 1'b1;
      end
      ST_PAIR: begin
        cmd.pair_load = 1'b1;
        cmd.prev_load = 1'b1;
      end
      ST_DIV:     cmd.div_step = 1'b1;
      ST_ACC: begin
        cmd.acc   = 1'b1;
        cmd.rd_en = !sts.pair_last;
      end
      ST_FIN:     cmd.out_load = !out_valid_r || out_tready;
      default:    cmd = '0;
    endcase
  end

  // Result valid flag: set on load, cleared when the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new result never overwrites one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending result");

  // Only one request is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second request accepted while busy");

  // A result only appears from the finish step.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result valid raised outside the finish step");

endmodule

FILE: rtl/crwt_dpath.sv
module crwt_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  crwt_pkg::cmd_t                       cmd,
  output crwt_pkg::sts_t                       sts,
  input  logic signed [crwt_pkg::H_W-1:0]      sample_height,
  input  logic [crwt_pkg::T_W-1:0]             sample_time,
  input  logic                                 in_flight,
  input  logic                                 cfg_we,
  input  logic [crwt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [crwt_pkg::RATE_W-1:0]          cfg_wdata,
  output logic                                 fire,
  output logic [crwt_pkg::RATE_W-1:0]          rate_average
);
  import crwt_pkg::*;

  // Configuration registers
  logic signed [H_W-1:0] hlo_r, hhi_r;
  logic [RATE_W-1:0]     rlo_r, rhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlo_r <= '0;
      hhi_r <= 16'sh7FFF;
      rlo_r <= '0;
      rhi_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HEIGHT_LOW:  hlo_r <= cfg_wdata;
        CFG_HEIGHT_HIGH: hhi_r <= cfg_wdata;
        CFG_RATE_LOW:    rlo_r <= cfg_wdata;
        CFG_RATE_HIGH:   rhi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Write slot and captured sample
  logic [SLOT_W-1:0]     wslot_r, wslot_nxt;
  logic signed [H_W-1:0] h_r;
  logic                  flying_r;

  assign wslot_nxt = (wslot_r == SLOT_W'(DEPTH - 1)) ? '0 : SLOT_W'(wslot_r + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r <= '0;
    end else if (cmd.capture) begin
      wslot_r <= wslot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      h_r      <= sample_height;
      flying_r <= in_flight;
    end
  end

  // Sample ring: one write port, one registered read port.
  // Entries never written read as zero through their valid bits.
  logic [H_W-1:0]    hmem [DEPTH];
  logic [T_W-1:0]    tmem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [SLOT_W-1:0] rd_addr_r, rd_addr_sel;
  logic [H_W-1:0]    rd_h_r;
  logic [T_W-1:0]    rd_t_r;
  logic              rd_v_r;

  assign rd_addr_sel = cmd.rd_first ? '0 : SLOT_W'(rd_addr_r + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hmem[wslot_nxt] <= sample_height;
      tmem[wslot_nxt] <= sample_time;
    end
    if (cmd.rd_en) begin
      rd_h_r    <= hmem[rd_addr_sel];
      rd_t_r    <= tmem[rd_addr_sel];
      rd_addr_r <= rd_addr_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      if (cmd.capture) valid_r[wslot_nxt] <= 1'b1;
      if (cmd.rd_en)   rd_v_r <= valid_r[rd_addr_sel];
    end
  end

  logic [H_W-1:0] cur_h;
  logic [T_W-1:0] cur_t;

  assign cur_h = rd_v_r ? rd_h_r : '0;
  assign cur_t = rd_v_r ? rd_t_r : '0;

  // Lower slot of the current pair
  logic [H_W-1:0] prev_h_r;
  logic [T_W-1:0] prev_t_r;

  always_ff @(posedge clk) begin
    if (cmd.prev_load) begin
      prev_h_r <= cur_h;
      prev_t_r <= cur_t;
    end
  end

  // Pair differences: 16-bit time magnitude and height magnitude
  logic [T_W-1:0]      diff_ab, diff_ba;
  logic [DIV_W-1:0]    dt16, dt_eff;
  logic signed [H_W:0] hd;
  logic [H_W:0]        hd_abs;
  logic [H_W-1:0]      dh;

  assign diff_ab = prev_t_r - cur_t;
  assign diff_ba = cur_t - prev_t_r;
  assign dt16    = (prev_t_r > cur_t) ? diff_ab[DIV_W-1:0] : diff_ba[DIV_W-1:0];
  assign dt_eff  = (dt16 == '0) ? DIV_W'(ZERO_DT) : dt16;
  assign hd      = {prev_h_r[H_W-1], prev_h_r} - {cur_h[H_W-1], cur_h};
  assign hd_abs  = hd[H_W] ? (H_W+1)'(-hd) : hd;
  assign dh      = hd_abs[H_W-1:0];

  // Restoring divider, one quotient bit per cycle
  logic [DVD_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] div_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W:0]   rem_sh, rem_sub;
  logic             rem_ge;

  assign rem_sh  = {rem_r, quo_r[DVD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (cmd.pair_load) begin
      quo_r <= DVD_W'(dh) * DVD_W'(RATE_SCALE);
      rem_r <= '0;
      div_r <= dt_eff;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DVD_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      cnt_r <= CNT_W'(cnt_r + 1'b1);
    end
  end

  assign sts.div_last  = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign sts.pair_last = (rd_addr_r == SLOT_W'(DEPTH - 2));

  // Saturating rate and running sum
  logic [RATE_W-1:0] sum_r;
  logic [RATE_W-1:0] qsat;
  logic [RATE_W:0]   sum_add;

  assign qsat    = (|quo_r[DVD_W-1:RATE_W]) ? '1 : quo_r[RATE_W-1:0];
  assign sum_add = {1'b0, sum_r} + {1'b0, qsat};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sum_r <= '0;
    end else if (cmd.acc) begin
      sum_r <= sum_add[RATE_W] ? '1 : sum_add[RATE_W-1:0];
    end
  end

  // Window compare and result register.
  // The ring depth is a power of two, so the average is a shift of the sum.
  logic [RATE_W-1:0] avg;
  logic              fire_nxt;

  assign avg      = RATE_W'(sum_r / DEPTH);
  assign fire_nxt = flying_r && (h_r > hlo_r) && (h_r < hhi_r)
                    && (avg > rlo_r) && (avg < rhi_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fire         <= fire_nxt;
      rate_average <= avg;
    end
  end

  // The zero-difference substitution keeps every rate divisor nonzero.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pair_load |=> (div_r != '0))
    else $error("rate division started with a zero divisor");

  // The running sum never falls while the pair rates accumulate.
  a_sum_rises: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |=> (sum_r >= $past(sum_r)))
    else $error("running rate sum decreased");

  // The pair sweep never reads past the last slot.
  a_rd_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && !cmd.rd_first) |-> (rd_addr_r < SLOT_W'(DEPTH - 1)))
    else $error("ring read beyond the last slot");

endmodule

FILE: rtl/climb_rate_window_trigger_core.sv
// Climb rate window trigger.
// Input stream: one request per sample (height, millisecond time stamp,
// in-flight flag). The sample goes into an eight-slot ring; the block then
// walks the adjacent slot pairs, forms dh * 1000 / dt for each with a
// shared one-bit-per-cycle divider and sums the saturated rates. The sum
// is divided by the ring depth with a shift, as the depth is a power of two.
// Output stream: one result per request with the fire level and the
// averaged rate. Configuration writes set the height and rate windows.
// One request is in work at a time: the block takes no new request
// until the current one has left the finish step, and most of that
// time goes to the pair divisions.
// Reset clears the ring to zeros, the write slot and the windows to their
// defaults. While the receiver stalls, a finished result waits in the output
// register; the block still takes the next request and holds that request's
// result until the earlier one has been taken.
module climb_rate_window_trigger_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [15:0] sample_height, [47:16] sample_time, [48] in_flight, rest zero
  input  logic [crwt_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [0] fire, [16:1] rate_average, rest zero
  output logic [crwt_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                   cfg_we,
  input  logic [crwt_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [crwt_pkg::RATE_W-1:0]            cfg_wdata
);
  import crwt_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              fire;
  logic [RATE_W-1:0] rate_average;

  crwt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  crwt_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .sample_height (in_tdata[H_W-1:0]),
    .sample_time   (in_tdata[H_W+T_W-1:H_W]),
    .in_flight     (in_tdata[H_W+T_W]),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fire          (fire),
    .rate_average  (rate_average)
  );

  assign out_tdata = {(OUT_TDATA_W - RATE_W - 1)'(0), rate_average, fire};

endmodule

FILE: tb/sv/climb_rate_checker.sv
// Watches the sample, result and register ports of the climb rate trigger,
// predicts one result per accepted sample and compares in order.
module climb_rate_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  // [15:0] sample_height, [47:16] sample_time, [48] in_flight, rest zero
  input  logic [crwt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] fire, [16:1] rate_average, rest zero
  input  logic [crwt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_we,
  input  logic [crwt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [crwt_pkg::RATE_W-1:0]        cfg_wdata,
  output int                                 mismatch_count,
  output int                                 pending_count
);
  import crwt_pkg::*;

  localparam int REPORT_LIMIT = 100;
  localparam int RATE_MAX     = 65535;

  typedef struct packed {
    logic              fire;
    logic [RATE_W-1:0] rate_average;
  } trigger_result_t;

  // Shadow copy of the windows and the sample rings.
  logic signed [H_W-1:0]    height_low;
  logic signed [H_W-1:0]    height_high;
  logic [RATE_W-1:0]        rate_low;
  logic [RATE_W-1:0]        rate_high;
  logic signed [H_W-1:0]    height_ring [DEPTH];
  logic [T_W-1:0]           time_ring [DEPTH];
  logic [SLOT_W-1:0]        write_slot;
  trigger_result_t          expected_results [$];

  // Sum of the saturated pair rates over the ring, divided by the depth.
  function automatic logic [RATE_W-1:0] ring_rate_average();
    int unsigned sum;
    int          pair;
    int          height_diff;
    longint      climb;
    longint      pair_rate;
    logic [T_W-1:0] span;
    logic [15:0] dt;
    sum = 0;
    for (pair = 0; pair < DEPTH - 2; pair++) begin
      span = (time_ring[pair] > time_ring[pair + 1]) ?
             time_ring[pair] - time_ring[pair + 1] :
             time_ring[pair + 1] - time_ring[pair];
      dt = span[15:0];
      if (dt == 16'd0) begin
        dt = 16'(ZERO_DT);
      end
      height_diff = int'(height_ring[pair]) - int'(height_ring[pair + 1]);
      climb = (height_diff < 0) ? -height_diff : height_diff;
      pair_rate = (climb * RATE_SCALE) / longint'(dt);
      if (pair_rate > RATE_MAX) begin
        pair_rate = RATE_MAX;
      end
      sum = sum + int'(pair_rate);
      if (sum > RATE_MAX) begin
        sum = RATE_MAX;
      end
    end
    return RATE_W'(sum / DEPTH);
  endfunction

  // Store the sample in the next slot and work out its result.
  function automatic trigger_result_t predict_trigger(logic signed [H_W-1:0] height,
                                                      logic [T_W-1:0] stamp,
                                                      logic flying);
    trigger_result_t res;
    write_slot = (write_slot == SLOT_W'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
    height_ring[write_slot] = height;
    time_ring[write_slot] = stamp;
    res.rate_average = ring_rate_average();
    res.fire = flying && (height > height_low) && (height < height_high) &&
               (res.rate_average > rate_low) && (res.rate_average < rate_high);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Check a delivered result against the oldest prediction.
  task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
    trigger_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("%0t: result with no request pending, expected none, actual fire %0d rate %0d",
                 $time, data[0], data[16:1]);
      end
    end else begin
      want = expected_results.pop_front();
      if (want.fire !== data[0]) begin
        report_mismatch("fire", want.fire, data[0]);
      end
      if (want.rate_average !== data[16:1]) begin
        report_mismatch("rate_average", want.rate_average, data[16:1]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      height_low <= 16'sd0;
      height_high <= 16'sd32767;
      rate_low <= '0;
      rate_high <= '1;
      for (int k = 0; k < DEPTH; k++) begin
        height_ring[k] = '0;
        time_ring[k] = '0;
      end
      write_slot = '0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_HEIGHT_LOW:  height_low <= signed'(cfg_wdata);
          CFG_HEIGHT_HIGH: height_high <= signed'(cfg_wdata);
          CFG_RATE_LOW:    rate_low <= cfg_wdata;
          CFG_RATE_HIGH:   rate_high <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_trigger(signed'(in_tdata[15:0]),
                                                   in_tdata[47:16], in_tdata[48]));
      end
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Drives samples and window settings into the climb rate trigger; the
// checker beside the block predicts and compares every result.
module tb;
  import crwt_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 192;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 250;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = CFG_HEIGHT_LOW;
  logic [RATE_W-1:0]       cfg_wdata = '0;
  int                      mismatch_count;
  int                      pending_count;

  // Percent chances of a sender idle cycle and a receiver stall cycle.
  int                      sender_idle_pct = 0;
  int                      receiver_stall_pct = 0;
  int                      quiet_cycles = 0;

  // State of the simulated flight trajectory.
  int                      traj_height = 0;
  logic [T_W-1:0]          traj_time = '0;

  climb_rate_window_trigger_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  climb_rate_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver side: random stalls at the rate of the current phase.
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one sample and hold it until the block takes it.
  task automatic send_sample(input logic [H_W-1:0] height, input logic [T_W-1:0] stamp,
                             input logic flying);
    if (sender_idle_pct > 0 && $urandom_range(7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 250)) @(negedge clk);
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata = {7'b0, flying, stamp, height};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [RATE_W-1:0] data);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_windows(input logic [H_W-1:0] h_lo, input logic [H_W-1:0] h_hi,
                             input logic [RATE_W-1:0] r_lo, input logic [RATE_W-1:0] r_hi);
    write_reg(CFG_HEIGHT_LOW, h_lo);
    write_reg(CFG_HEIGHT_HIGH, h_hi);
    write_reg(CFG_RATE_LOW, r_lo);
    write_reg(CFG_RATE_HIGH, r_hi);
  endtask

  // Mostly a plausible climb with random pace, plus noise and edge samples.
  task automatic send_random_sample();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      if ($urandom_range(99) == 0) begin
        traj_time = $urandom;
        traj_height = 0;
      end
      traj_time = traj_time + $urandom_range(1, 150);
      traj_height = traj_height + int'($urandom_range(0, 40)) - 8;
      if (traj_height < -300 || traj_height > 4000) begin
        traj_height = $urandom_range(0, 500);
      end
      send_sample(H_W'(traj_height), traj_time, $urandom_range(9) != 0);
    end else if (roll < 82) begin
      send_sample(H_W'($urandom), $urandom, 1'($urandom));
    end else if (roll < 90) begin
      // Same time stamp as the last trajectory sample.
      traj_height = traj_height + int'($urandom_range(0, 200)) - 100;
      send_sample(H_W'(traj_height), traj_time, 1'b1);
    end else if (roll < 95) begin
      // Time step that is a whole multiple of 65536 ms.
      traj_time = traj_time + 32'h10000 * $urandom_range(1, 3);
      send_sample(H_W'(traj_height), traj_time, 1'b1);
    end else begin
      traj_time = traj_time + $urandom_range(0, 3);
      send_sample($urandom_range(1) ? 16'h7FFF : 16'h8000, traj_time, 1'($urandom));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed samples under the reset windows.
    send_sample(16'd0, 32'd0, 1'b0);
    send_sample(16'd100, 32'd1000, 1'b1);
    send_sample(16'h8000, 32'd2000, 1'b1);
    send_sample(16'h7FFF, 32'd2001, 1'b1);
    send_sample(16'h7FFF, 32'd2001, 1'b1);
    send_sample(16'h7FFE, 32'd2001 + 32'h10000, 1'b1);
    send_sample(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_sample(16'd1, 32'd0, 1'b1);
    send_sample(16'd0, 32'h8000_0000, 1'b1);
    send_sample(16'd500, 32'h8000_0000, 1'b0);
    for (int step = 0; step < 10; step++) begin
      send_sample(H_W'(600 + 50 * step), 32'h8000_0064 + 100 * step, 1'b1);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_all_results();
      case (phase)
        0: set_windows(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF);
        1: set_windows(16'd0, 16'd3000, 16'd10, 16'd2000);
        2: set_windows(16'h7FFF, 16'h8000, 16'hFFFF, 16'd0);
        3: set_windows(-16'sd300, 16'd4000, 16'd0, 16'd200);
        4: set_windows(H_W'($urandom), H_W'($urandom), RATE_W'($urandom), RATE_W'($urandom));
        5: set_windows(16'd100, 16'd1500, 16'd50, 16'hFFFF);
        6: set_windows(16'h8000, 16'd0, 16'd0, 16'hFFFF);
        default: set_windows(16'h8000, 16'h7FFF, 16'd5, 16'd7);
      endcase
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 63;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 63;
        end
        default: begin
          sender_idle_pct = 7;
          receiver_stall_pct = 7;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then hold off until the block has delivered everything.
        if ($urandom_range(49) == 0) begin
          wait_all_results();
        end
        send_random_sample();
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
